>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");

// Condition must never be seen outside reset.
`define CHK_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen: %m");

`endif

>>> design/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 hasher.
`timescale 1ns / 1ps

package sha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [0:7][31:0] hash_t;

  localparam int unsigned NumRounds = 64;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LastFitFill = 6'd55;

  localparam hash_t InitHash = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Requests from the sequencer to the round unit.
  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sig1(word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sig0(word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> design/sha_core.sv
// SHA-256 round unit: chaining state, working registers and round counter.
`timescale 1ns / 1ps

module sha_core import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  core_ctrl_t ctrl_i,
  input  word_t      w_i,
  output core_stat_t stat_o,
  output hash_t      chain_o
);

  hash_t      chain_q;
  hash_t      work_q;
  hash_t      work_d;
  logic [5:0] rnd_q;
  logic       busy_q;
  logic       fin_q;

  word_t t1;
  word_t t2;
  word_t ch;
  word_t mj;

  always_comb begin
    ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    mj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1 = work_q[7] + big_sig1(work_q[4]) + ch + RoundK[rnd_q] + w_i;
    t2 = big_sig0(work_q[0]) + mj;
    work_d[0] = t1 + t2;
    work_d[1] = work_q[0];
    work_d[2] = work_q[1];
    work_d[3] = work_q[2];
    work_d[4] = work_q[3] + t1;
    work_d[5] = work_q[4];
    work_d[6] = work_q[5];
    work_d[7] = work_q[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitHash;
      work_q  <= '0;
      rnd_q   <= '0;
      busy_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      if (ctrl_i.init) begin
        chain_q <= InitHash;
      end
      if (ctrl_i.start) begin
        work_q <= chain_q;
        rnd_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        work_q <= work_d;
        rnd_q  <= rnd_q + 6'd1;
        if (rnd_q == 6'(NumRounds - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      // fold the working registers into the chaining state
      if (fin_q) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + work_q[i];
        end
        fin_q <= 1'b0;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = fin_q;
  assign chain_o     = chain_q;

endmodule

>>> design/sha256_message_hasher.sv
// SHA-256 message hasher top level: byte packing, padding and digest output.
`timescale 1ns / 1ps

// Takes a message one byte per request (last_byte_i ends it; with no_data_i it
// adds no byte, hashing an empty message if none came before) and returns eight
// 32-bit digest words, word 0 first. Bytes are taken one per cycle while a block
// fills. Every 64th byte starts a compression (64 rounds on the single shared
// round unit, then a fold into the chaining state) during which in_ready_o is
// low. After the last request the padding words are pushed one per cycle (up to
// 16 per padding block), one or two compressions follow, and the eight digest
// words are offered one per cycle while out_ready_i is high; the next message is
// taken after the final digest word is accepted. The round unit sets the rate.
module sha256_message_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        no_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_COMP, ST_OUT} state_e;

  state_e      state_q;
  logic [5:0]  fill_q;
  logic [63:0] bitlen_q;
  logic        pad_q;
  logic        first_q;
  logic        len_ok_q;
  logic        final_q;
  logic [2:0]  out_cnt_q;
  word_t       acc_q;
  word_t       block_q [16];

  core_ctrl_t  core_ctrl;
  core_stat_t  core_stat;
  hash_t       chain;

  logic        accept;
  logic        take_byte;
  logic        out_fire;
  logic [3:0]  wi;
  logic [4:0]  sh;
  word_t       byte_word;
  word_t       pad_word;
  word_t       pad_src;
  word_t       sched_word;
  logic        len_now;
  logic        push_byte;
  logic        push_pad;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign accept     = in_valid_i && in_ready_o;
  assign take_byte  = accept && !no_data_i;
  assign out_fire   = out_valid_o && out_ready_i;

  assign wi = fill_q[5:2];
  assign sh = {~fill_q[1:0], 3'b000};

  always_comb begin
    if (fill_q[1:0] == 2'd0) begin
      byte_word = {data_byte_i, 24'd0};
      pad_word  = {PadByte, 24'd0};
    end else begin
      byte_word = acc_q | ({24'd0, data_byte_i} << sh);
      pad_word  = acc_q | ({24'd0, PadByte} << sh);
    end
  end

  assign len_now = first_q ? (fill_q <= LastFitFill) : len_ok_q;

  always_comb begin
    if (first_q) begin
      pad_src = pad_word;
    end else if (len_ok_q && wi == 4'd14) begin
      pad_src = bitlen_q[63:32];
    end else if (len_ok_q && wi == 4'd15) begin
      pad_src = bitlen_q[31:0];
    end else begin
      pad_src = '0;
    end
  end

  assign push_byte = take_byte && (fill_q[1:0] == 2'd3);
  assign push_pad  = (state_q == ST_PAD);

  // next schedule word from the 16-word window
  assign sched_word = small_sig1(block_q[14]) + block_q[9] + small_sig0(block_q[1]) + block_q[0];

  assign core_ctrl.start = (take_byte && fill_q == 6'd63) || (push_pad && wi == 4'd15);
  assign core_ctrl.init  = out_fire && digest_last_o;

  sha_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (core_ctrl),
    .w_i     (block_q[0]),
    .stat_o  (core_stat),
    .chain_o (chain)
  );

  // block buffer as a shift line: words enter at the top, rounds read the bottom
  always_ff @(posedge clk_i) begin
    if (take_byte) begin
      acc_q <= byte_word;
    end
    if (push_byte || push_pad || core_stat.busy) begin
      for (int i = 0; i < 15; i++) begin
        block_q[i] <= block_q[i + 1];
      end
      if (core_stat.busy) begin
        block_q[15] <= sched_word;
      end else if (push_pad) begin
        block_q[15] <= pad_src;
      end else begin
        block_q[15] <= byte_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      bitlen_q  <= '0;
      pad_q     <= 1'b0;
      first_q   <= 1'b0;
      len_ok_q  <= 1'b0;
      final_q   <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pad_q   <= last_byte_i;
            first_q <= last_byte_i;
            if (!no_data_i) begin
              fill_q   <= fill_q + 6'd1;
              bitlen_q <= bitlen_q + 64'd8;
            end
            if (core_ctrl.start) begin
              state_q <= ST_COMP;
            end else if (last_byte_i) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          fill_q  <= {wi + 4'd1, 2'b00};
          first_q <= 1'b0;
          if (first_q) begin
            len_ok_q <= (fill_q <= LastFitFill);
          end
          if (wi == 4'd15) begin
            state_q <= ST_COMP;
            final_q <= len_now;
            pad_q   <= !len_now;
            // length goes into a second padding block
            if (!len_now) begin
              len_ok_q <= 1'b1;
            end
          end
        end
        ST_COMP: begin
          if (core_stat.done) begin
            if (final_q) begin
              state_q <= ST_OUT;
            end else if (pad_q) begin
              state_q <= ST_PAD;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (out_fire) begin
            out_cnt_q <= out_cnt_q + 3'd1;
            if (digest_last_o) begin
              state_q  <= ST_IDLE;
              fill_q   <= '0;
              bitlen_q <= '0;
              pad_q    <= 1'b0;
              final_q  <= 1'b0;
              len_ok_q <= 1'b0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign digest_word_o = chain[out_cnt_q];
  assign digest_last_o = (out_cnt_q == 3'd7);

endmodule

>>> design/sha_checker.sv
// Port-level checker for the SHA-256 hasher, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic        digest_last_o
);

  // hold a stalled digest word
  `CHK_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(digest_word_o) && $stable(digest_last_o)))

  // no request is taken while digest words are pending
  `CHK_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o)

  // the digest burst continues until its last word
  `CHK_ASSERT(a_burst_cont, clk_i, rst_ni, (out_valid_o && out_ready_i && !digest_last_o) |=> out_valid_o)

  // the last digest word ends the burst and frees the input
  `CHK_ASSERT(a_burst_end, clk_i, rst_ni, (out_valid_o && out_ready_i && digest_last_o) |=> (!out_valid_o && in_ready_o))

  // a message that is still filling never ends with digest words directly
  `CHK_ASSERT(a_no_early_out, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !out_valid_o)

endmodule

bind sha256_message_hasher sha_checker u_sha_checker (.*);

>>> tb/sv/sha256_message_hasher_test.sv
// Testbench for sha256_message_hasher: byte stream in, digest words checked against a local model.
`timescale 1ns / 1ps

module sha256_message_hasher_test;

  typedef struct packed {
    logic [31:0] word;
    logic        is_final;
  } digest_beat_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         is_last;
    logic         no_byte;
    logic         typed;
    logic [255:0] digest;
  } stim_row_t;

  localparam logic [255:0] EmptyDigest =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] AbcDigest =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;
  localparam logic [7:0] MsgPad = 8'h80;
  localparam int NumRows = 11;
  localparam int RandomItems = 250;

  localparam logic [31:0] ShaIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Empty message, "abc", empty items, single extreme bytes, end marker after data.
  stim_row_t directed_rows [NumRows] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1, EmptyDigest},
    '{8'h61, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h62, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b0, 1'b1, AbcDigest},
    '{8'hff, 1'b0, 1'b1, 1'b0, 256'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'ha5, 1'b0, 1'b1, 1'b0, 256'h0},
    '{8'h5a, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h00, 1'b1, 1'b1, 1'b1, EmptyDigest},
    '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        no_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic        digest_last_o;

  // Local hash state
  logic [31:0] hash_chain [8];
  logic [7:0]  block_bytes [64];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  digest_beat_t expected_beats [$];
  int           fail_count;
  int           items_sent;
  bit           burst_mode;

  sha256_message_hasher u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .no_data_i     (no_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .digest_last_o (digest_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    hash_chain = ShaIv;
    block_fill = 0;
    msg_bits   = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    v = hash_chain;
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ShaK[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) hash_chain[i] = hash_chain[i] + v[i];
  endfunction

  // Absorb one request; returns 1 with the digest when the message ends.
  function automatic bit hash_request(input logic [7:0] b, input bit is_last,
                                      input bit no_byte, output logic [255:0] digest);
    int i;
    digest = '0;
    if (!no_byte) begin
      block_bytes[block_fill] = b;
      block_fill++;
      msg_bits = msg_bits + 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (!is_last) return 1'b0;
    block_bytes[block_fill] = MsgPad;
    block_fill++;
    // No room left for the length: spill into a second block.
    if (block_fill > 56) begin
      for (i = block_fill; i < 64; i++) block_bytes[i] = 8'h00;
      compress_block();
      block_fill = 0;
    end
    for (i = block_fill; i < 56; i++) block_bytes[i] = 8'h00;
    for (i = 0; i < 8; i++) block_bytes[56+i] = msg_bits[63-8*i -: 8];
    compress_block();
    for (i = 0; i < 8; i++) digest[255-32*i -: 32] = hash_chain[i];
    restart_hash();
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [7:0] b, input bit is_last, input bit no_byte,
                              input bit typed, input logic [255:0] typed_digest);
    int gap;
    bit done;
    logic [255:0] digest;
    digest_beat_t beat;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    data_byte_i = b;
    last_byte_i = is_last;
    no_data_i   = no_byte;
    do @(posedge clk_i); while (!in_ready_o);
    done = hash_request(b, is_last, no_byte, digest);
    if (done) begin
      if (typed) digest = typed_digest;
      for (int k = 0; k < 8; k++) begin
        beat.word     = digest[255-32*k -: 32];
        beat.is_final = (k == 7);
        expected_beats = {expected_beats, beat};
      end
    end
    @(negedge clk_i);
  endtask

  task automatic drain_digests();
    in_valid_i = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_message(input int len, input bit end_marker);
    int i;
    for (i = 0; i < len; i++) begin
      // Drop in an empty request now and then.
      if ($urandom_range(0, 9) == 0) begin
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
        items_sent++;
      end
      send_request(8'($urandom_range(0, 255)), (i == len - 1) && !end_marker, 1'b0, 1'b0,
                   '0);
      items_sent++;
    end
    if (end_marker) begin
      send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, '0);
      items_sent++;
    end
  endtask

  // Digest receiver
  initial begin
    int stall;
    digest_beat_t want;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected digest word %h last %b", $time, digest_word_o, digest_last_o);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (digest_word_o !== want.word) begin
          $display("%0t: digest_word expected %h actual %h", $time, want.word, digest_word_o);
          fail_count++;
        end
        if (digest_last_o !== want.is_final) begin
          $display("%0t: digest_last expected %b actual %b", $time, want.is_final,
                   digest_last_o);
          fail_count++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    int len;
    bit end_marker;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    last_byte_i = 1'b0;
    no_data_i   = 1'b0;
    fail_count  = 0;
    items_sent  = 0;
    burst_mode  = 1'b0;
    restart_hash();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      send_request(directed_rows[r].data, directed_rows[r].is_last, directed_rows[r].no_byte,
                   directed_rows[r].typed, directed_rows[r].digest);
      items_sent++;
    end
    // Hold the stream until every digest is out.
    drain_digests();

    while (items_sent < RandomItems) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) drain_digests();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(1, 12);
        4:          len = $urandom_range(54, 57);
        5:          len = $urandom_range(62, 66);
        6:          len = $urandom_range(118, 122);
        7:          len = 0;
        default:    len = $urandom_range(13, 50);
      endcase
      // Keep the total near the planned item count.
      if (len > RandomItems - items_sent) len = RandomItems - items_sent;
      end_marker = (len == 0) || ($urandom_range(0, 3) == 0);
      send_message(len, end_marker);
    end
    burst_mode = 1'b0;
    drain_digests();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** sha256_message_hasher: PASSED **");
    end else begin
      $display("** sha256_message_hasher: FAILED **");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("%0t: timeout", $time);
    $display("** sha256_message_hasher: FAILED **");
    $finish;
  end

endmodule
